### rtl/core/pfq_pkg.sv
// Shared types, constants and helpers for the packet descriptor queue.
// Used by every module of the block except pfq_ram; depends on nothing.
package pfq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int ADDR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int KIND_W  = 2;
    localparam int WORD_W  = 16;
    localparam int POS_W   = 6;
    localparam int STAT_W  = 3;
    localparam int PCNT_W  = 7;
    localparam int BYTE_W  = 22;
    localparam int CMP_W   = (CNT_W > PCNT_W) ? CNT_W : PCNT_W;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 64;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam int CMD_DEPTH = 2;
    localparam int CMD_PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

    localparam int RAM_W = 2 * WORD_W;

    localparam logic REG_MAX_PACKETS = 1'b0;
    localparam logic REG_MAX_BYTES   = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_ENQ  = 2'd0,
        KIND_POP  = 2'd1,
        KIND_PEEK = 2'd2,
        KIND_NOP  = 2'd3
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 3'd0,
        STAT_COUNT = 3'd1,
        STAT_BYTES = 3'd2,
        STAT_EMPTY = 3'd3,
        STAT_FULL  = 3'd4
    } t_status;

    typedef enum logic {
        ST_EXEC = 1'b0,
        ST_READ = 1'b1
    } t_back_state;

    typedef struct packed {
        t_op               op;
        logic [WORD_W-1:0] handle;
        logic [WORD_W-1:0] length;
        logic [POS_W-1:0]  position;
    } t_cmd;

    typedef struct packed {
        logic [PCNT_W-1:0] max_packets;
        logic [BYTE_W-1:0] max_bytes;
    } t_cfg;

    function automatic logic [ADDR_W-1:0] slot_add(input logic [ADDR_W-1:0] base,
                                                   input logic [CNT_W-1:0]  off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
            sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

### rtl/core/packet_fifo_tail_drop_queue_unit.sv
// Top level of the tail-drop packet descriptor queue.
// Depends on pfq_pkg, pfq_regs, pfq_front, pfq_cmd_fifo, pfq_back.
//
//  channel   | direction | tdata (low bit up)                                   | tuser
//  s_*       | in        | handle[15:0] length[31:16] position[37:32]           | kind[1:0]
//  m_*       | out       | handle[15:0] length[31:16] count[38:32] bytes[60:39] | status[2:0]
//  apb       | in        | limit registers: max_packets @0x0, max_bytes @0x4    | -
//
// Enqueue, unused kinds, empty pop and out-of-range peek finish in the execution state;
// a pop or peek that finds a descriptor also goes through the read state for the registered read.
// Input to result passes the input register, the command queue and the execution stage.
// Reset clears pointers, counters and limits; descriptor memory is not cleared.
// Either side may stall; the input side keeps accepting until the command queue fills.
module packet_fifo_tail_drop_queue_unit
    import pfq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,   // handle, length, position, zero pad
    input  logic [KIND_W-1:0]    i_s_tuser,   // kind
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,   // handle, length, count, bytes, zero pad
    output logic [STAT_W-1:0]    o_m_tuser,   // status
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    t_cfg cfg;
    logic front_valid;
    logic fifo_full;
    t_cmd front_cmd;
    logic fifo_valid;
    t_cmd fifo_cmd;
    logic fifo_pop;

    pfq_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pfq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_cmd_valid (front_valid),
        .i_cmd_ready (!fifo_full),
        .o_cmd       (front_cmd)
    );

    pfq_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_cmd   (front_cmd),
        .o_full  (fifo_full),
        .i_pop   (fifo_pop),
        .o_valid (fifo_valid),
        .o_cmd   (fifo_cmd)
    );

    pfq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd_valid (fifo_valid),
        .i_cmd       (fifo_cmd),
        .o_cmd_pop   (fifo_pop),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

endmodule

### rtl/core/pfq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
module pfq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/pfq_regs.sv
// APB register file holding the packet and byte limits.
// Depends on pfq_pkg.
module pfq_regs
    import pfq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (paddr[2])
                REG_MAX_PACKETS: n_cfg.max_packets = pwdata[PCNT_W-1:0];
                REG_MAX_BYTES:   n_cfg.max_bytes   = pwdata[BYTE_W-1:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_MAX_PACKETS: prdata = PDATA_W'(r_cfg.max_packets);
            REG_MAX_BYTES:   prdata = PDATA_W'(r_cfg.max_bytes);
            default:         prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/core/pfq_front.sv
// Input stage: register the incoming item and classify its kind into an op.
// Depends on pfq_pkg; feeds pfq_cmd_fifo.
module pfq_front
    import pfq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    input  logic [KIND_W-1:0]    i_s_tuser,
    output logic                 o_cmd_valid,
    input  logic                 i_cmd_ready,
    output t_cmd                 o_cmd
);

    logic r_valid;
    logic n_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic take;

    assign o_s_tready = !r_valid || i_cmd_ready;
    assign take       = i_s_tvalid && o_s_tready;

    always_comb begin
        n_cmd          = r_cmd;
        n_cmd.handle   = i_s_tdata[WORD_W-1:0];
        n_cmd.length   = i_s_tdata[2*WORD_W-1:WORD_W];
        n_cmd.position = i_s_tdata[2*WORD_W+POS_W-1:2*WORD_W];
        unique case (i_s_tuser)
            KIND_ENQ:  n_cmd.op = KIND_ENQ;
            KIND_POP:  n_cmd.op = KIND_POP;
            KIND_PEEK: n_cmd.op = KIND_PEEK;
            default:   n_cmd.op = KIND_NOP;
        endcase
    end

    always_comb begin
        if (take) begin
            n_valid = 1'b1;
        end else if (i_cmd_ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

endmodule

### rtl/core/pfq_cmd_fifo.sv
// Short command queue decoupling the front stage from the execution stage.
// Depends on pfq_pkg.
module pfq_cmd_fifo
    import pfq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd                 r_mem [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] r_wr_ptr;
    logic [CMD_PTR_W-1:0] r_rd_ptr;
    logic [CMD_CNT_W-1:0] r_cnt;
    logic [CMD_PTR_W-1:0] n_wr_ptr;
    logic [CMD_PTR_W-1:0] n_rd_ptr;
    logic [CMD_CNT_W-1:0] n_cnt;
    logic                 do_push;
    logic                 do_pop;

    assign o_full  = (r_cnt == CMD_CNT_W'(CMD_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

### rtl/core/pfq_back.sv
// Execution stage: admission checks, descriptor storage, counters, result register.
// Depends on pfq_pkg and pfq_ram.
module pfq_back
    import pfq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg                 i_cfg,
    input  logic                 i_cmd_valid,
    input  t_cmd                 i_cmd,
    output logic                 o_cmd_pop,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,
    output logic [STAT_W-1:0]    o_m_tuser
);

    t_back_state        r_state;
    t_back_state        n_state;
    logic [ADDR_W-1:0]  r_head;
    logic [ADDR_W-1:0]  n_head;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic [BYTE_W-1:0]  r_bytes;
    logic [BYTE_W-1:0]  n_bytes;
    logic               r_pend_pop;
    logic               r_out_valid;
    logic               n_out_valid;
    t_status            r_out_status;
    t_status            n_out_status;
    logic [WORD_W-1:0]  r_out_handle;
    logic [WORD_W-1:0]  n_out_handle;
    logic [WORD_W-1:0]  r_out_length;
    logic [WORD_W-1:0]  n_out_length;
    logic [PCNT_W-1:0]  r_out_count;
    logic [BYTE_W-1:0]  r_out_bytes;

    logic               out_free;
    logic               exec_go;
    logic               read_done;
    logic               load_out;
    logic               ram_we;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [RAM_W-1:0]   ram_rdata;
    logic [ADDR_W-1:0]  tail_slot;
    logic [BYTE_W:0]    enq_sum;
    logic               cnt_fail;
    logic               byte_fail;
    logic               full_fail;
    logic               peek_hit;
    t_status            enq_status;

    assign out_free = !r_out_valid || i_m_tready;

    assign tail_slot = slot_add(r_head, r_count);
    assign enq_sum   = (BYTE_W+1)'(r_bytes) + (BYTE_W+1)'(i_cmd.length);
    assign cnt_fail  = (i_cfg.max_packets != '0)
                    && (CMP_W'(r_count) >= CMP_W'(i_cfg.max_packets));
    assign byte_fail = ((i_cfg.max_bytes != '0) && (enq_sum > (BYTE_W+1)'(i_cfg.max_bytes)))
                    || enq_sum[BYTE_W];
    assign full_fail = (r_count >= CNT_W'(QUEUE_DEPTH));
    assign peek_hit  = (CMP_W'(i_cmd.position) < CMP_W'(r_count));

    always_comb begin
        priority if (cnt_fail) begin
            enq_status = STAT_COUNT;
        end else if (byte_fail) begin
            enq_status = STAT_BYTES;
        end else if (full_fail) begin
            enq_status = STAT_FULL;
        end else begin
            enq_status = STAT_OK;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_EXEC: begin
                if (i_cmd_valid && out_free) begin
                    if ((i_cmd.op == KIND_POP && r_count != '0)
                        || (i_cmd.op == KIND_PEEK && peek_hit)) begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: begin
                if (out_free) begin
                    n_state = ST_EXEC;
                end
            end
            default: n_state = ST_EXEC;
        endcase
    end

    // control outputs
    always_comb begin
        exec_go   = 1'b0;
        read_done = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = r_head;
        load_out  = 1'b0;
        unique case (r_state)
            ST_EXEC: begin
                exec_go = i_cmd_valid && out_free;
                if (exec_go) begin
                    unique case (i_cmd.op)
                        KIND_ENQ: begin
                            ram_we   = (enq_status == STAT_OK);
                            load_out = 1'b1;
                        end
                        KIND_POP: begin
                            ram_re   = (r_count != '0);
                            load_out = (r_count == '0);
                        end
                        KIND_PEEK: begin
                            ram_re    = peek_hit;
                            ram_raddr = slot_add(r_head, CNT_W'(i_cmd.position));
                            load_out  = !peek_hit;
                        end
                        default: load_out = 1'b1;
                    endcase
                end
            end
            ST_READ: begin
                read_done = out_free;
                load_out  = out_free;
            end
            default: ;
        endcase
    end

    assign o_cmd_pop = exec_go;

    // datapath next values
    always_comb begin
        n_head       = r_head;
        n_count      = r_count;
        n_bytes      = r_bytes;
        n_out_status = STAT_EMPTY;
        n_out_handle = '0;
        n_out_length = '0;
        if (read_done) begin
            n_out_status = STAT_OK;
            n_out_handle = ram_rdata[WORD_W-1:0];
            n_out_length = ram_rdata[RAM_W-1:WORD_W];
            if (r_pend_pop) begin
                n_head  = (r_head == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
                n_count = r_count - 1'b1;
                n_bytes = r_bytes - BYTE_W'(ram_rdata[RAM_W-1:WORD_W]);
            end
        end else if (exec_go && i_cmd.op == KIND_ENQ) begin
            n_out_status = enq_status;
            if (enq_status == STAT_OK) begin
                n_count = r_count + 1'b1;
                n_bytes = enq_sum[BYTE_W-1:0];
            end
        end
    end

    always_comb begin
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_EXEC;
            r_head      <= '0;
            r_count     <= '0;
            r_bytes     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_bytes     <= n_bytes;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ram_re) begin
            r_pend_pop <= (i_cmd.op == KIND_POP);
        end
        if (load_out) begin
            r_out_status <= n_out_status;
            r_out_handle <= n_out_handle;
            r_out_length <= n_out_length;
            r_out_count  <= PCNT_W'(n_count);
            r_out_bytes  <= n_bytes;
        end
    end

    pfq_ram #(
        .WIDTH (RAM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (tail_slot),
        .i_wdata ({i_cmd.length, i_cmd.handle}),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = M_TDATA_W'({r_out_bytes, r_out_count, r_out_length, r_out_handle});

endmodule

### rtl/core/pfq_checker.sv
// Port-level checks for the packet descriptor queue, bound to the top level.
// Depends on pfq_pkg and packet_fifo_tail_drop_queue_unit.
module pfq_checker
    import pfq_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_m_tvalid,
    input logic                 i_m_tready,
    input logic [M_TDATA_W-1:0] o_m_tdata,
    input logic [STAT_W-1:0]    o_m_tuser
);

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser != STAT_OK) |-> (o_m_tdata[2*WORD_W-1:0] == '0))
        else $error("refused item returned a descriptor");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (CMP_W'(o_m_tdata[2*WORD_W+PCNT_W-1:2*WORD_W])
                        <= CMP_W'(QUEUE_DEPTH)))
        else $error("packet count beyond depth");

    a_empty_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[2*WORD_W+PCNT_W-1:2*WORD_W] == '0)
        |-> (o_m_tdata[2*WORD_W+PCNT_W+BYTE_W-1:2*WORD_W+PCNT_W] == '0))
        else $error("empty queue with nonzero byte total");

endmodule

bind packet_fifo_tail_drop_queue_unit pfq_checker u_pfq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

### tb/tb.sv
// Self-checking bench for the tail-drop packet descriptor queue.
// Needs pfq_pkg and packet_fifo_tail_drop_queue_unit; predicts every result in-line
// and walks a directed table followed by randomized enqueue/pop/peek traffic.
module tb;
    import pfq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_ITEMS = 600;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned NUM_ROWS     = 26;
    localparam longint     TIMEOUT_NS    = 2_000_000;

    localparam logic [PADDR_W-1:0] ADDR_MAX_PACKETS = {REG_MAX_PACKETS, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_MAX_BYTES   = {REG_MAX_BYTES, 2'b00};
    localparam int unsigned        BYTE_LIMIT       = (1 << BYTE_W) - 1;

    typedef struct packed {
        t_status           status;
        logic [WORD_W-1:0] handle;
        logic [WORD_W-1:0] length;
        logic [PCNT_W-1:0] count;
        logic [BYTE_W-1:0] bytes;
    } t_result;

    typedef struct packed {
        bit                set_cfg;
        logic [PCNT_W-1:0] cfg_packets;
        logic [BYTE_W-1:0] cfg_bytes;
        logic [6:0]        reps;
        t_op               kind;
        logic [WORD_W-1:0] handle;
        logic [WORD_W-1:0] length;
        logic [POS_W-1:0]  position;
        bit                typed;
        t_result           want;
    } t_row;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata  = '0;   // handle, length, position, zero pad
    logic [KIND_W-1:0]    i_s_tuser  = '0;   // kind
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_tdata;         // handle, length, count, bytes, zero pad
    logic [STAT_W-1:0]    o_m_tuser;         // status
    logic                 psel       = 1'b0;
    logic                 penable    = 1'b0;
    logic                 pwrite     = 1'b0;
    logic [PADDR_W-1:0]   paddr      = '0;
    logic [PDATA_W-1:0]   pwdata     = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    packet_fifo_tail_drop_queue_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Verification failed");
        $finish;
    end

    // Descriptor queue as the block should hold it.
    logic [WORD_W-1:0] desc_handle [QUEUE_DEPTH];
    logic [WORD_W-1:0] desc_length [QUEUE_DEPTH];
    int unsigned       model_head  = 0;
    int unsigned       model_count = 0;
    int unsigned       model_bytes = 0;
    int unsigned       lim_packets = 0;
    int unsigned       lim_bytes   = 0;

    t_result     pending_results [$];
    int unsigned error_count  = 0;
    int unsigned tx_idle_pct  = 0;
    int unsigned rx_idle_pct  = 0;
    bit          hold_request = 1'b0;
    bit          tx_active    = 1'b0;

    t_row dir_rows [NUM_ROWS] = '{
        // cfg  packets bytes          reps  kind        handle    length    pos  chk
        '{1'b0, 7'd0,  22'd0,       7'd1,  KIND_POP,  16'h0000, 16'h0000, 6'd0,  1'b1,
          '{STAT_EMPTY, 16'h0000, 16'h0000, 7'd0,  22'd0}},
        '{1'b0, 7'd0,  22'd0,       7'd1,  KIND_PEEK, 16'h1234, 16'h4321, 6'd0,  1'b1,
          '{STAT_EMPTY, 16'h0000, 16'h0000, 7'd0,  22'd0}},
        '{1'b0, 7'd0,  22'd0,       7'd1,  KIND_NOP,  16'hFFFF, 16'hFFFF, 6'd63, 1'b1,
          '{STAT_EMPTY, 16'h0000, 16'h0000, 7'd0,  22'd0}},
        '{1'b0, 7'd0,  22'd0,       7'd1,  KIND_ENQ,  16'hFFFF, 16'hFFFF, 6'd63, 1'b1,
          '{STAT_OK,    16'h0000, 16'h0000, 7'd1,  22'd65535}},
        '{1'b0, 7'd0,  22'd0,       7'd1,  KIND_ENQ,  16'h0000, 16'h0000, 6'd0,  1'b1,
          '{STAT_OK,    16'h0000, 16'h0000, 7'd2,  22'd65535}},
        '{1'b0, 7'd0,  22'd0,       7'd1,  KIND_PEEK, 16'hFFFF, 16'hFFFF, 6'd1,  1'b1,
          '{STAT_OK,    16'h0000, 16'h0000, 7'd2,  22'd65535}},
        '{1'b0, 7'd0,  22'd0,       7'd1,  KIND_PEEK, 16'h0000, 16'h0000, 6'd63, 1'b1,
          '{STAT_EMPTY, 16'h0000, 16'h0000, 7'd2,  22'd65535}},
        '{1'b0, 7'd0,  22'd0,       7'd1,  KIND_PEEK, 16'h0000, 16'h0000, 6'd0,  1'b1,
          '{STAT_OK,    16'hFFFF, 16'hFFFF, 7'd2,  22'd65535}},
        '{1'b0, 7'd0,  22'd0,       7'd1,  KIND_POP,  16'h0000, 16'h0000, 6'd0,  1'b1,
          '{STAT_OK,    16'hFFFF, 16'hFFFF, 7'd1,  22'd0}},
        '{1'b0, 7'd0,  22'd0,       7'd1,  KIND_POP,  16'hFFFF, 16'hFFFF, 6'd63, 1'b1,
          '{STAT_OK,    16'h0000, 16'h0000, 7'd0,  22'd0}},
        '{1'b0, 7'd0,  22'd0,       7'd64, KIND_ENQ,  16'hA5A5, 16'hFFFF, 6'd0,  1'b0, '0},
        '{1'b0, 7'd0,  22'd0,       7'd1,  KIND_ENQ,  16'h5A5A, 16'h0000, 6'd0,  1'b1,
          '{STAT_FULL,  16'h0000, 16'h0000, 7'd64, 22'd4194240}},
        '{1'b0, 7'd0,  22'd0,       7'd1,  KIND_ENQ,  16'h5A5A, 16'h003F, 6'd0,  1'b1,
          '{STAT_FULL,  16'h0000, 16'h0000, 7'd64, 22'd4194240}},
        '{1'b0, 7'd0,  22'd0,       7'd1,  KIND_ENQ,  16'h5A5A, 16'h0040, 6'd0,  1'b1,
          '{STAT_BYTES, 16'h0000, 16'h0000, 7'd64, 22'd4194240}},
        '{1'b0, 7'd0,  22'd0,       7'd1,  KIND_PEEK, 16'h0000, 16'h0000, 6'd63, 1'b1,
          '{STAT_OK,    16'hA5A5, 16'hFFFF, 7'd64, 22'd4194240}},
        '{1'b0, 7'd0,  22'd0,       7'd64, KIND_POP,  16'h0000, 16'h0000, 6'd0,  1'b0, '0},
        '{1'b0, 7'd0,  22'd0,       7'd1,  KIND_POP,  16'h0000, 16'h0000, 6'd0,  1'b1,
          '{STAT_EMPTY, 16'h0000, 16'h0000, 7'd0,  22'd0}},
        '{1'b0, 7'd0,  22'd0,       7'd1,  KIND_ENQ,  16'h0001, 16'h0064, 6'd0,  1'b1,
          '{STAT_OK,    16'h0000, 16'h0000, 7'd1,  22'd100}},
        '{1'b0, 7'd0,  22'd0,       7'd1,  KIND_ENQ,  16'h0002, 16'h0032, 6'd0,  1'b1,
          '{STAT_OK,    16'h0000, 16'h0000, 7'd2,  22'd150}},
        '{1'b1, 7'd1,  22'd100,     7'd1,  KIND_ENQ,  16'h0003, 16'h0000, 6'd0,  1'b1,
          '{STAT_COUNT, 16'h0000, 16'h0000, 7'd2,  22'd150}},
        '{1'b0, 7'd0,  22'd0,       7'd1,  KIND_POP,  16'h0000, 16'h0000, 6'd0,  1'b1,
          '{STAT_OK,    16'h0001, 16'h0064, 7'd1,  22'd50}},
        '{1'b0, 7'd0,  22'd0,       7'd1,  KIND_POP,  16'h0000, 16'h0000, 6'd0,  1'b1,
          '{STAT_OK,    16'h0002, 16'h0032, 7'd0,  22'd0}},
        '{1'b0, 7'd0,  22'd0,       7'd1,  KIND_ENQ,  16'h0004, 16'h0065, 6'd0,  1'b1,
          '{STAT_BYTES, 16'h0000, 16'h0000, 7'd0,  22'd0}},
        '{1'b0, 7'd0,  22'd0,       7'd1,  KIND_ENQ,  16'h0005, 16'h0064, 6'd0,  1'b1,
          '{STAT_OK,    16'h0000, 16'h0000, 7'd1,  22'd100}},
        '{1'b0, 7'd0,  22'd0,       7'd1,  KIND_ENQ,  16'h0006, 16'hFFFF, 6'd0,  1'b1,
          '{STAT_COUNT, 16'h0000, 16'h0000, 7'd1,  22'd100}},
        '{1'b1, 7'd64, 22'd4194303, 7'd1,  KIND_POP,  16'h0000, 16'h0000, 6'd0,  1'b1,
          '{STAT_OK,    16'h0005, 16'h0064, 7'd0,  22'd0}}
    };

    function automatic t_result predict_queue_op(input t_op               kind,
                                                 input logic [WORD_W-1:0] hnd,
                                                 input logic [WORD_W-1:0] len,
                                                 input logic [POS_W-1:0]  pos);
        t_result     res;
        int unsigned total;
        int unsigned slot;
        res        = '0;
        res.status = STAT_EMPTY;
        case (kind)
            KIND_ENQ: begin
                total = model_bytes + len;
                if (lim_packets != 0 && model_count >= lim_packets) begin
                    res.status = STAT_COUNT;
                end else if ((lim_bytes != 0 && total > lim_bytes) || total > BYTE_LIMIT) begin
                    res.status = STAT_BYTES;
                end else if (model_count >= QUEUE_DEPTH) begin
                    res.status = STAT_FULL;
                end else begin
                    slot = (model_head + model_count) % QUEUE_DEPTH;
                    desc_handle[slot] = hnd;
                    desc_length[slot] = len;
                    model_count++;
                    model_bytes = total;
                    res.status  = STAT_OK;
                end
            end
            KIND_POP: begin
                if (model_count != 0) begin
                    res.handle  = desc_handle[model_head];
                    res.length  = desc_length[model_head];
                    model_bytes = model_bytes - res.length;
                    model_count--;
                    model_head  = (model_head + 1) % QUEUE_DEPTH;
                    res.status  = STAT_OK;
                end
            end
            KIND_PEEK: begin
                if (pos < model_count) begin
                    slot       = (model_head + pos) % QUEUE_DEPTH;
                    res.handle = desc_handle[slot];
                    res.length = desc_length[slot];
                    res.status = STAT_OK;
                end
            end
            default: begin
            end
        endcase
        res.count = PCNT_W'(model_count);
        res.bytes = BYTE_W'(model_bytes);
        return res;
    endfunction

    task automatic stop_sending();
        if (tx_active) begin
            i_s_tvalid <= 1'b0;
            tx_active = 1'b0;
        end
    endtask

    task automatic send_item(input t_op               kind,
                             input logic [WORD_W-1:0] hnd,
                             input logic [WORD_W-1:0] len,
                             input logic [POS_W-1:0]  pos,
                             input bit                typed,
                             input t_result           want);
        t_result predicted;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= {2'b00, pos, len, hnd};
        tx_active = 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        predicted = predict_queue_op(kind, hnd, len, pos);
        pending_results = {pending_results, (typed ? want : predicted)};
    endtask

    task automatic idle_after_item();
        if ($urandom_range(99) < tx_idle_pct) begin
            stop_sending();
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        stop_sending();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_limits(input logic [PCNT_W-1:0] packets,
                                input logic [BYTE_W-1:0] bytes);
        apb_write(ADDR_MAX_PACKETS, PDATA_W'(packets));
        lim_packets = packets;
        apb_write(ADDR_MAX_BYTES, PDATA_W'(bytes));
        lim_bytes = bytes;
    endtask

    initial begin : result_sink
        t_result     got;
        t_result     want;
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                got.status = t_status'(o_m_tuser);
                got.handle = o_m_tdata[15:0];
                got.length = o_m_tdata[31:16];
                got.count  = o_m_tdata[38:32];
                got.bytes  = o_m_tdata[60:39];
                if (pending_results.size() == 0) begin
                    $error("result item with nothing pending: status %0d", got.status);
                    error_count++;
                end else begin
                    want = pending_results[0];
                    pending_results.delete(0);
                    if (got.status !== want.status) begin
                        $error("status expected %0d actual %0d", want.status, got.status);
                        error_count++;
                    end
                    if (got.handle !== want.handle) begin
                        $error("handle_out expected %0h actual %0h", want.handle, got.handle);
                        error_count++;
                    end
                    if (got.length !== want.length) begin
                        $error("length_out expected %0d actual %0d", want.length, got.length);
                        error_count++;
                    end
                    if (got.count !== want.count) begin
                        $error("packet_count expected %0d actual %0d", want.count, got.count);
                        error_count++;
                    end
                    if (got.bytes !== want.bytes) begin
                        $error("byte_total expected %0d actual %0d", want.bytes, got.bytes);
                        error_count++;
                    end
                end
            end
            if (hold_request) begin
                hold_left = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial begin : item_source
        int unsigned       row;
        int unsigned       random_sent;
        int unsigned       ep_len;
        int unsigned       k;
        int unsigned       enq_pct;
        int unsigned       r;
        int unsigned       mode;
        t_op               kind;
        logic [WORD_W-1:0] hnd;
        logic [WORD_W-1:0] len;
        logic [POS_W-1:0]  pos;
        logic [PCNT_W-1:0] packets;
        logic [BYTE_W-1:0] bytes;

        tx_idle_pct = 14;
        rx_idle_pct = 60;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (row = 0; row < NUM_ROWS; row++) begin
            if (dir_rows[row].set_cfg) begin
                wait_idle();
                write_limits(dir_rows[row].cfg_packets, dir_rows[row].cfg_bytes);
            end
            repeat (dir_rows[row].reps) begin
                send_item(dir_rows[row].kind, dir_rows[row].handle, dir_rows[row].length,
                          dir_rows[row].position, dir_rows[row].typed, dir_rows[row].want);
                idle_after_item();
            end
        end

        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            case ($urandom_range(5))
                0: begin packets = '0; bytes = '0; end
                1: begin packets = PCNT_W'(64); bytes = BYTE_W'(BYTE_LIMIT); end
                2: begin packets = PCNT_W'($urandom_range(1, 8)); bytes = '0; end
                3: begin packets = '0; bytes = BYTE_W'($urandom_range(1, 300000)); end
                4: begin
                    packets = PCNT_W'($urandom_range(1, 127));
                    bytes   = BYTE_W'($urandom_range(BYTE_LIMIT));
                end
                default: begin
                    packets = PCNT_W'(1);
                    bytes   = BYTE_W'($urandom_range(70000));
                end
            endcase
            wait_idle();
            write_limits(packets, bytes);
            case ($urandom_range(2))
                0: enq_pct = 35;
                1: enq_pct = 50;
                default: enq_pct = 75;
            endcase
            ep_len = $urandom_range(40, 100);
            for (k = 0; k < ep_len && random_sent < RANDOM_ITEMS; k++) begin
                mode = random_sent / (RANDOM_ITEMS / 3);
                tx_idle_pct = (mode == 0) ? 14 : (mode == 1) ? 60 : 0;
                rx_idle_pct = (mode == 0) ? 60 : (mode == 1) ? 14 : 0;
                if (random_sent == 60) hold_request = 1'b1;
                r = $urandom_range(99);
                if (r < enq_pct) kind = KIND_ENQ;
                else if (r < enq_pct + (100 - enq_pct) / 2) kind = KIND_POP;
                else if (r < 98) kind = KIND_PEEK;
                else kind = KIND_NOP;
                hnd = WORD_W'($urandom_range(16'hFFFF));
                r = $urandom_range(99);
                if (r < 60) len = WORD_W'($urandom_range(2047));
                else if (r < 90) len = WORD_W'($urandom_range(16'hFFFF));
                else len = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                if (model_count != 0 && $urandom_range(3) != 0) begin
                    pos = POS_W'($urandom_range(model_count - 1));
                end else begin
                    pos = POS_W'($urandom_range(63));
                end
                send_item(kind, hnd, len, pos, 1'b0, '0);
                random_sent++;
                idle_after_item();
            end
        end

        stop_sending();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
